// File: design/bqsj_pkg.sv
// ---------------------------------------------------------------------------
// bqsj_pkg
// Types and constants shared by the bilinear quad shape/Jacobian block.
// ---------------------------------------------------------------------------
package bqsj_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int NAT_WIDTH = 16;
	localparam int ONE_Q14 = 16384;
	localparam int DET_WIDTH = 48;
	localparam int SLOPE_WIDTH = 32;
	localparam int NUM_NODES = 4;

	typedef struct packed {
		logic signed [31:0] node1_x;
		logic signed [31:0] node1_y;
		logic signed [31:0] node2_x;
		logic signed [31:0] node2_y;
		logic signed [31:0] node3_x;
		logic signed [31:0] node3_y;
		logic signed [31:0] node4_x;
		logic signed [31:0] node4_y;
		logic signed [15:0] xi;
		logic signed [15:0] eta;
	} bqsj_in_t;

	typedef struct packed {
		logic [1:0]         node_index;
		logic [14:0]        shape_value;
		logic signed [31:0] slope_x;
		logic signed [31:0] slope_y;
		logic signed [47:0] jacobian_det;
		logic               singular;
		logic               last_of_item;
	} bqsj_out_t;

	// Natural gradients, quadrupled, of one node.
	typedef struct packed {
		logic signed [17:0] gxi;
		logic signed [17:0] geta;
	} bqsj_grad_t;

	// Per-item values handed from the Jacobian stage to the slope stage.
	typedef struct packed {
		logic signed [17:0] mx;
		logic signed [17:0] px;
		logic signed [17:0] me;
		logic signed [17:0] pe;
		logic signed [62:0] jxx;
		logic signed [62:0] jxe;
		logic signed [62:0] jyx;
		logic signed [62:0] jye;
		logic signed [47:0] det;
	} bqsj_jac_t;

	function automatic bqsj_grad_t grad_of(input logic [1:0] idx, input logic signed [17:0] mx,
			input logic signed [17:0] px, input logic signed [17:0] me,
			input logic signed [17:0] pe);
		bqsj_grad_t g;
		case (idx)
			2'd0: begin g.gxi = -me; g.geta = -mx; end
			2'd1: begin g.gxi = me; g.geta = -px; end
			2'd2: begin g.gxi = pe; g.geta = px; end
			default: begin g.gxi = -pe; g.geta = mx; end
		endcase
		return g;
	endfunction

endpackage

// File: design/bilinear_quad_shape_jacobian.sv
// ---------------------------------------------------------------------------
// bilinear_quad_shape_jacobian
// Four-node quad shape values, Jacobian determinant and physical slopes.
// Results come out one a cycle, four per item, once an accepted start has
// passed the Jacobian pipeline, the numerator registers and the dividers.
// A start is taken only while busy is low; busy rises after each accepted one.
// The receiver cannot stall. Reset clears all valid bits and the sequencer.
// ---------------------------------------------------------------------------
module bilinear_quad_shape_jacobian import bqsj_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  bqsj_in_t  operand,
	output logic      result_valid,
	output bqsj_out_t result
);

	localparam int NW = 96;
	localparam int TW = 2 + 15 + 48 + 1;

	logic      acc;
	logic [1:0] busy_q;
	logic      jv;
	bqsj_jac_t jd;

	assign acc = start && !busy;
	assign busy = busy_q != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 2'd0;
		end else if (acc) begin
			busy_q <= 2'd3;
		end else if (busy_q != 2'd0) begin
			busy_q <= busy_q - 2'd1;
		end
	end

	bqsj_jac #(.COORD_WIDTH(COORD_WIDTH)) u_jac (
		.clk(clk), .arst_n(arst_n), .in_valid(acc), .in_data(operand),
		.out_valid(jv), .out_data(jd)
	);

	// Node sequencer: holds one item and issues its four nodes.
	logic [1:0] idx_q;
	logic       act_q;
	bqsj_jac_t  hold_q;
	bqsj_jac_t  cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (jv) begin
			act_q <= 1'b1;
			idx_q <= 2'd1;
		end else if (act_q) begin
			idx_q <= idx_q + 2'd1;
			if (idx_q == 2'd3) begin
				act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (jv) begin
			hold_q <= jd;
		end
	end

	logic       nv;
	logic [1:0] ni;
	assign cur = jv ? jd : hold_q;
	assign nv = jv || act_q;
	assign ni = jv ? 2'd0 : idx_q;

	// Numerator products, registered.
	bqsj_grad_t g;
	logic signed [35:0] nat;
	logic [14:0] sv;
	logic signed [81:0] a_s, b_s, c_s, e_s;
	logic [1:0] ni_s;
	logic [14:0] sv_s;
	logic signed [47:0] det_s;
	logic nv_s;

	always_comb begin
		g = grad_of(ni, cur.mx, cur.px, cur.me, cur.pe);
		case (ni)
			2'd0: nat = 36'(cur.mx) * 36'(cur.me);
			2'd1: nat = 36'(cur.px) * 36'(cur.me);
			2'd2: nat = 36'(cur.px) * 36'(cur.pe);
			default: nat = 36'(cur.mx) * 36'(cur.pe);
		endcase
		if (nat < 36'sd0) begin
			sv = 15'd0;
		end else if (((nat + 36'sd32768) >>> 16) > 36'sd32767) begin
			sv = 15'h7FFF;
		end else begin
			sv = 15'((nat + 36'sd32768) >>> 16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_s <= 1'b0;
		end else begin
			nv_s <= nv;
		end
	end

	always_ff @(posedge clk) begin
		a_s <= 82'(g.gxi) * 82'(cur.jye);
		b_s <= 82'(g.geta) * 82'(cur.jyx);
		c_s <= 82'(g.geta) * 82'(cur.jxx);
		e_s <= 82'(g.gxi) * 82'(cur.jxe);
		ni_s <= ni;
		sv_s <= sv;
		det_s <= cur.det;
	end

	logic signed [NW-1:0] nx, ny;
	logic [TW-1:0] tag_in, tag_x, tag_y;
	logic dvx, dvy;
	logic signed [31:0] qx, qy;
	logic signed [47:0] dden;

	assign nx = NW'(a_s) - NW'(b_s);
	assign ny = NW'(c_s) - NW'(e_s);
	assign tag_in = {ni_s, sv_s, det_s, (det_s == 48'sd0)};
	assign dden = (det_s == 48'sd0) ? 48'sd1 : det_s;

	bqsj_div #(.NW(NW), .TW(TW)) u_divx (
		.clk(clk), .arst_n(arst_n), .in_valid(nv_s), .num(nx), .den(dden),
		.in_tag(tag_in), .out_valid(dvx), .quot(qx), .out_tag(tag_x)
	);

	bqsj_div #(.NW(NW), .TW(TW)) u_divy (
		.clk(clk), .arst_n(arst_n), .in_valid(nv_s), .num(ny), .den(dden),
		.in_tag(tag_in), .out_valid(dvy), .quot(qy), .out_tag(tag_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= dvx && dvy;
		end
	end

	always_ff @(posedge clk) begin
		result.node_index <= tag_x[TW-1 -: 2];
		result.shape_value <= tag_x[TW-3 -: 15];
		result.jacobian_det <= tag_x[48:1];
		result.singular <= tag_x[0];
		result.slope_x <= tag_x[0] ? 32'sd0 : qx;
		result.slope_y <= tag_y[0] ? 32'sd0 : qy;
		result.last_of_item <= tag_x[TW-1 -: 2] == 2'd3;
	end

endmodule

// File: design/bqsj_jac.sv
// ---------------------------------------------------------------------------
// bqsj_jac
// Jacobian pipeline: four-tap sums, rounding, and determinant.
// ---------------------------------------------------------------------------
module bqsj_jac import bqsj_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  bqsj_in_t  in_data,
	output logic      out_valid,
	output bqsj_jac_t out_data
);

	localparam int PW = COORD_WIDTH + 18;
	localparam int SW = PW + 2;

	logic signed [COORD_WIDTH-1:0] cx [4];
	logic signed [COORD_WIDTH-1:0] cy [4];
	logic signed [17:0] mx, px, me, pe;
	logic signed [17:0] gxi [4];
	logic signed [17:0] geta [4];

	assign cx[0] = in_data.node1_x[COORD_WIDTH-1:0];
	assign cy[0] = in_data.node1_y[COORD_WIDTH-1:0];
	assign cx[1] = in_data.node2_x[COORD_WIDTH-1:0];
	assign cy[1] = in_data.node2_y[COORD_WIDTH-1:0];
	assign cx[2] = in_data.node3_x[COORD_WIDTH-1:0];
	assign cy[2] = in_data.node3_y[COORD_WIDTH-1:0];
	assign cx[3] = in_data.node4_x[COORD_WIDTH-1:0];
	assign cy[3] = in_data.node4_y[COORD_WIDTH-1:0];
	assign mx = 18'(ONE_Q14) - 18'(in_data.xi);
	assign px = 18'(ONE_Q14) + 18'(in_data.xi);
	assign me = 18'(ONE_Q14) - 18'(in_data.eta);
	assign pe = 18'(ONE_Q14) + 18'(in_data.eta);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			gxi[i] = grad_of(2'(i), mx, px, me, pe).gxi;
			geta[i] = grad_of(2'(i), mx, px, me, pe).geta;
		end
	end

	// Stage 1: sixteen products.
	logic              v_s1;
	logic signed [PW-1:0] pxx_s1 [4], pxe_s1 [4], pyx_s1 [4], pye_s1 [4];
	logic signed [17:0] mx_s1, px_s1, me_s1, pe_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			pxx_s1[i] <= PW'(cx[i]) * PW'(gxi[i]);
			pxe_s1[i] <= PW'(cx[i]) * PW'(geta[i]);
			pyx_s1[i] <= PW'(cy[i]) * PW'(gxi[i]);
			pye_s1[i] <= PW'(cy[i]) * PW'(geta[i]);
		end
		mx_s1 <= mx;
		px_s1 <= px;
		me_s1 <= me;
		pe_s1 <= pe;
	end

	// Stage 2: sums, rounded to Q16.16. Width stays below 63 bits.
	logic v_s2;
	logic signed [62:0] jxx_s2, jxe_s2, jyx_s2, jye_s2;
	logic signed [17:0] mx_s2, px_s2, me_s2, pe_s2;

	function automatic logic signed [62:0] rsum(input logic signed [PW-1:0] a,
			input logic signed [PW-1:0] b, input logic signed [PW-1:0] c,
			input logic signed [PW-1:0] d);
		logic signed [SW-1:0] s;
		s = SW'(a) + SW'(b) + SW'(c) + SW'(d) + SW'(32768);
		return 63'(s >>> 16);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		jxx_s2 <= rsum(pxx_s1[0], pxx_s1[1], pxx_s1[2], pxx_s1[3]);
		jxe_s2 <= rsum(pxe_s1[0], pxe_s1[1], pxe_s1[2], pxe_s1[3]);
		jyx_s2 <= rsum(pyx_s1[0], pyx_s1[1], pyx_s1[2], pyx_s1[3]);
		jye_s2 <= rsum(pye_s1[0], pye_s1[1], pye_s1[2], pye_s1[3]);
		mx_s2 <= mx_s1;
		px_s2 <= px_s1;
		me_s2 <= me_s1;
		pe_s2 <= pe_s1;
	end

	// Stage 3: the two determinant products.
	localparam int JW = SW - 16;
	localparam int DW = 2 * JW + 1;
	logic v_s3;
	logic signed [DW-1:0] pa_s3, pb_s3;
	bqsj_jac_t j_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		pa_s3 <= DW'(jxx_s2) * DW'(jye_s2);
		pb_s3 <= DW'(jxe_s2) * DW'(jyx_s2);
		j_s3.mx <= mx_s2;
		j_s3.px <= px_s2;
		j_s3.me <= me_s2;
		j_s3.pe <= pe_s2;
		j_s3.jxx <= jxx_s2;
		j_s3.jxe <= jxe_s2;
		j_s3.jyx <= jyx_s2;
		j_s3.jye <= jye_s2;
		j_s3.det <= '0;
	end

	// Stage 4: difference, rounding and saturation of the determinant.
	logic signed [DW+1:0] dsum;
	logic signed [DW+1:0] dsh;
	logic signed [47:0] dsat;
	bqsj_jac_t j_o;

	always_comb begin
		dsum = (DW+2)'(pa_s3) - (DW+2)'(pb_s3) + (DW+2)'(32768);
		dsh = dsum >>> 16;
		if (dsh > (DW+2)'(48'sh7FFF_FFFF_FFFF)) begin
			dsat = 48'sh7FFF_FFFF_FFFF;
		end else if (dsh < -(DW+2)'(49'sh8000_0000_0000)) begin
			dsat = 48'sh8000_0000_0000;
		end else begin
			dsat = dsh[47:0];
		end
		j_o = j_s3;
		j_o.det = dsat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= j_o;
	end

endmodule

// File: design/bqsj_div.sv
// ---------------------------------------------------------------------------
// bqsj_div
// Pipelined restoring divider, one quotient bit a stage, with rounding
// half away from zero and saturation to 32 bits.
// ---------------------------------------------------------------------------
module bqsj_div import bqsj_pkg::*; #(
	parameter int NW = 96,
	parameter int TW = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic signed [NW-1:0]   num,
	input  logic signed [47:0]     den,
	input  logic [TW-1:0]          in_tag,
	output logic                   out_valid,
	output logic signed [31:0]     quot,
	output logic [TW-1:0]          out_tag
);

	// Quotient magnitudes at or above 2^34 saturate, so with the divisor
	// at least 1 the numerator above bit QB+47 never matters; a quick check
	// of high bits against the divisor flags overflow instead.
	localparam int QB = 34;
	localparam int NS = QB + 1;

	typedef struct packed {
		logic          neg;
		logic          ovf;
		logic [NW-1:0] rem;
		logic [47:0]   d;
		logic [QB-1:0] q;
		logic [TW-1:0] tag;
	} st_t;

	st_t  st [NS];
	logic vld [NS];

	logic [NW-1:0] nmag;
	logic [47:0]   dmag;
	logic          ovf0;

	assign nmag = num[NW-1] ? NW'(-num) : NW'(num);
	assign dmag = den[47] ? 48'(-den) : 48'(den);
	// Overflow when nmag >= d * 2^QB.
	assign ovf0 = (nmag >> QB) >= NW'(dmag);

	function automatic st_t stage_step(input st_t s, input int i);
		st_t r;
		logic [NW:0] trial;
		logic [NW:0] sub;
		r = s;
		trial = (NW+1)'(s.rem);
		sub = (NW+1)'(s.d) << (QB - i);
		if (trial >= sub) begin
			r.rem = NW'(trial - sub);
			r.q[QB-i] = 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				vld[i] <= 1'b0;
			end
		end else begin
			vld[0] <= in_valid;
			for (int i = 1; i < NS; i++) begin
				vld[i] <= vld[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		st[0].neg <= num[NW-1] ^ den[47];
		st[0].ovf <= ovf0;
		st[0].rem <= nmag;
		st[0].d <= dmag;
		st[0].q <= '0;
		st[0].tag <= in_tag;
		for (int i = 1; i < NS; i++) begin
			st[i] <= stage_step(st[i-1], i);
		end
	end

	logic [QB:0] qr;
	logic        rup;
	st_t         fin;

	assign fin = st[NS-1];
	assign rup = ({fin.rem, 1'b0} >= (NW+1)'(fin.d));
	assign qr = (QB+1)'(fin.q) + (QB+1)'(rup);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		out_tag <= fin.tag;
		if (fin.neg) begin
			if (fin.ovf || qr >= (QB+1)'(33'h0_8000_0000)) begin
				quot <= 32'sh8000_0000;
			end else begin
				quot <= 32'(-qr);
			end
		end else begin
			if (fin.ovf || qr > (QB+1)'(32'h7FFF_FFFF)) begin
				quot <= 32'sh7FFF_FFFF;
			end else begin
				quot <= qr[31:0];
			end
		end
	end

endmodule
